FILE: hdl/gha_pkg.sv
`timescale 1ns / 1ps

package gha_pkg;

    localparam int MAX_SLOTS_DEF = 1024;
    localparam int GEN_W         = 32;
    localparam int IN_IDX_W      = 32;
    localparam int OUT_IDX_W     = 10;
    localparam int S_TDATA_W     = 72;
    localparam int M_TDATA_W     = 48;

    localparam logic [1:0] OP_CREATE   = 2'd0;
    localparam logic [1:0] OP_FREE     = 2'd1;
    localparam logic [1:0] OP_VALIDATE = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_NOROOM  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_EXEC
    } state_t;

endpackage

FILE: hdl/gha_ram.sv
`timescale 1ns / 1ps

module gha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/generational_handle_allocator.sv
`timescale 1ns / 1ps

// channel   ports         tdata fields, lowest bit up
// input     s_tvalid/rdy  op[1:0] slot_index[33:2] entity_generation[65:34]
// result    m_tvalid/rdy  status[1:0] result_index[11:2] result_generation[43:12]
//
// an item takes a memory read, then a compute and write-back step; a create that pops
// the free stack also passes S_POP, as the stack read comes before the generation read.
// reset clears the state, the counters and the result valid flag, not the memories; slots
// at or above the high-water mark read as generation zero and are written with zero when first handed out.
// a stalled result holds the block in its last step; the next item is taken
// once the result register has been loaded.

module generational_handle_allocator
    import gha_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // op, slot_index, entity_generation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status, result_index, result_generation
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] fcnt_reg, fcnt_next;
    logic [CNT_W-1:0] hw_reg, hw_next;

    logic [1:0]          op_reg;
    logic [IN_IDX_W-1:0] idx_reg;
    logic [GEN_W-1:0]    gin_reg;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic accept, fire;

    logic [1:0]          s_op;
    logic [IN_IDX_W-1:0] s_idx;
    logic [GEN_W-1:0]    s_gen;

    logic             gen_wr_en, gen_rd_en;
    logic [IDX_W-1:0] gen_wr_addr, gen_rd_addr;
    logic [GEN_W-1:0] gen_wr_data, gen_rd_data;

    logic             stk_wr_en;
    logic [IDX_W-1:0] stk_wr_addr, stk_rd_addr, stk_wr_data, stk_rd_data;

    logic [1:0]          res_status;
    logic [IN_IDX_W-1:0] res_slot;
    logic [GEN_W-1:0]    res_gen;
    logic                in_range;
    logic [GEN_W-1:0]    gen_inc;

    assign s_op  = s_tdata[1:0];
    assign s_idx = s_tdata[33:2];
    assign s_gen = s_tdata[65:34];

    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    gha_ram #(
        .WIDTH (GEN_W),
        .DEPTH (MAX_SLOTS)
    ) u_gen_ram (
        .aclk    (aclk),
        .wr_en   (gen_wr_en),
        .wr_addr (gen_wr_addr),
        .wr_data (gen_wr_data),
        .rd_en   (gen_rd_en),
        .rd_addr (gen_rd_addr),
        .rd_data (gen_rd_data)
    );

    gha_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_SLOTS)
    ) u_stk_ram (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (accept),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // stack top read at accept; wraps harmlessly when the stack is empty
    assign stk_rd_addr = IDX_W'(fcnt_reg - CNT_W'(1));

    // generation read: handle index at accept, popped slot in the S_POP state
    assign gen_rd_en   = accept || (state_reg == S_POP);
    assign gen_rd_addr = (state_reg == S_POP) ? stk_rd_data : s_idx[IDX_W-1:0];

    assign in_range = (idx_reg < IN_IDX_W'(hw_reg));
    assign gen_inc  = gin_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_op == OP_CREATE && fcnt_reg != '0) begin
                        state_next = S_POP;
                    end else begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_POP: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (fire) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // execute step: result, write back, counter updates
    always_comb begin
        res_status  = STAT_INVALID;
        res_slot    = '0;
        res_gen     = '0;
        gen_wr_en   = 1'b0;
        gen_wr_addr = idx_reg[IDX_W-1:0];
        gen_wr_data = gen_rd_data + GEN_W'(1);
        stk_wr_en   = 1'b0;
        stk_wr_addr = fcnt_reg[IDX_W-1:0];
        stk_wr_data = idx_reg[IDX_W-1:0];
        fcnt_next   = fcnt_reg;
        hw_next     = hw_reg;
        case (op_reg)
            OP_CREATE: begin
                if (fcnt_reg != '0) begin
                    res_status = STAT_OK;
                    res_slot   = IN_IDX_W'(stk_rd_data);
                    res_gen    = gen_rd_data;
                    fcnt_next  = fcnt_reg - CNT_W'(1);
                end else if (hw_reg < CNT_W'(MAX_SLOTS)) begin
                    // fresh slot: clear whatever the memory held before reset
                    res_status  = STAT_OK;
                    res_slot    = IN_IDX_W'(hw_reg);
                    res_gen     = '0;
                    gen_wr_en   = fire;
                    gen_wr_addr = hw_reg[IDX_W-1:0];
                    gen_wr_data = '0;
                    hw_next     = hw_reg + CNT_W'(1);
                end else begin
                    res_status = STAT_NOROOM;
                end
            end
            OP_FREE: begin
                if (in_range) begin
                    res_slot  = idx_reg;
                    res_gen   = gen_rd_data + GEN_W'(1);
                    gen_wr_en = fire;
                    if (fcnt_reg == CNT_W'(MAX_SLOTS)) begin
                        res_status = STAT_NOROOM;
                    end else begin
                        res_status = STAT_OK;
                        stk_wr_en  = fire;
                        fcnt_next  = fcnt_reg + CNT_W'(1);
                    end
                end
            end
            OP_VALIDATE: begin
                if (in_range && gen_rd_data == gen_inc) begin
                    res_status = STAT_OK;
                    res_slot   = idx_reg;
                    res_gen    = gin_reg;
                end
            end
            default: begin
                res_status = STAT_INVALID;
            end
        endcase
    end

    // result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0, res_gen, res_slot[OUT_IDX_W-1:0], res_status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fcnt_reg     <= '0;
            hw_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (fire) begin
                fcnt_reg <= fcnt_next;
                hw_reg   <= hw_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (accept) begin
            op_reg  <= s_op;
            idx_reg <= s_idx;
            gin_reg <= s_gen;
        end
    end

`ifndef SYNTH
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fcnt_reg <= CNT_W'(MAX_SLOTS)) && (hw_reg <= CNT_W'(MAX_SLOTS)))
        else $error("free count or high-water mark beyond slot count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_EXEC))
        else $error("result appeared without an execute step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (fcnt_reg != $past(fcnt_reg) || hw_reg != $past(hw_reg))
        |-> $past(fire))
        else $error("counters moved outside a committed execute step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP) |=> (state_reg == S_EXEC))
        else $error("stack pop not followed by execute");
`endif

endmodule

FILE: bench/tb_generational_handle_allocator.sv
`timescale 1ns / 1ps

module tb_generational_handle_allocator;
    import gha_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SLOTS = MAX_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_LIMIT = 40;
    localparam int S_PAD_W = S_TDATA_W - 2 - IN_IDX_W - GEN_W;

    typedef struct packed {
        logic [1:0]           status;
        logic [OUT_IDX_W-1:0] index;
        logic [GEN_W-1:0]     generation;
    } reply_t;

    class allocator_scoreboard;
        logic [GEN_W-1:0]     gen_table [SLOTS];
        logic [OUT_IDX_W-1:0] free_stack [SLOTS];
        int                   free_count;
        int                   high_water;
        int                   create_refused;
        int                   push_refused;
        int                   errors;
        reply_t               pending_replies [$];

        function new();
            foreach (gen_table[i]) gen_table[i] = '0;
            foreach (free_stack[i]) free_stack[i] = '0;
            free_count = 0;
            high_water = 0;
            create_refused = 0;
            push_refused = 0;
            errors = 0;
        endfunction

        function reply_t predict_reply(logic [1:0] op, logic [31:0] idx, logic [31:0] gen);
            reply_t r;
            int     slot;
            r = '0;
            r.status = STAT_INVALID;
            case (op)
                OP_CREATE: begin
                    // recycled slots first, newest freed on top
                    if (free_count > 0) begin
                        free_count--;
                        slot = int'(free_stack[free_count]);
                    end else if (high_water < SLOTS) begin
                        slot = high_water;
                        high_water++;
                    end else begin
                        r.status = STAT_NOROOM;
                        create_refused++;
                        return r;
                    end
                    r.status = STAT_OK;
                    r.index = slot[OUT_IDX_W-1:0];
                    r.generation = gen_table[slot];
                end
                OP_FREE: begin
                    if (idx < high_water) begin
                        slot = int'(idx);
                        gen_table[slot] = gen_table[slot] + 1'b1;
                        r.index = slot[OUT_IDX_W-1:0];
                        r.generation = gen_table[slot];
                        // generation still bumps when the push is refused
                        if (free_count >= SLOTS) begin
                            r.status = STAT_NOROOM;
                            push_refused++;
                        end else begin
                            free_stack[free_count] = slot[OUT_IDX_W-1:0];
                            free_count++;
                            r.status = STAT_OK;
                        end
                    end
                end
                OP_VALIDATE: begin
                    if (idx < high_water && gen_table[int'(idx)] == gen) begin
                        r.status = STAT_OK;
                        r.index = idx[OUT_IDX_W-1:0];
                        r.generation = gen;
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("ERROR @%0t: %s", $time, msg);
        endtask

        function void note_request(logic [1:0] op, logic [31:0] idx, logic [31:0] gen);
            pending_replies.push_back(predict_reply(op, idx, gen));
        endfunction

        task check_reply(reply_t got);
            reply_t want;
            if (pending_replies.size() == 0) begin
                report($sformatf("result with nothing pending: status %0d index %0d gen %h",
                                 got.status, got.index, got.generation));
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d, expected %0d", got.status, want.status));
                if (got.index !== want.index)
                    report($sformatf("result_index %0d, expected %0d", got.index, want.index));
                if (got.generation !== want.generation)
                    report($sformatf("result_generation %h, expected %h",
                                     got.generation, want.generation));
            end
        endtask

        task final_check();
            while (pending_replies.size() > 0) begin
                void'(pending_replies.pop_front());
                report("expected result never arrived");
            end
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // op, slot_index, entity_generation
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // status, result_index, result_generation

    allocator_scoreboard sb;
    bit                  quiet;
    int                  cycles;

    always #4 aclk = ~aclk;

    generational_handle_allocator #(
        .MAX_SLOTS(SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    function automatic int idle_draw();
        return quiet ? 0 : int'($urandom_range(0, 4));
    endfunction

    always @(posedge aclk) begin
        reply_t got;
        cycles++;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata[1:0], s_tdata[33:2], s_tdata[65:34]);
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[1:0];
                got.index = m_tdata[11:2];
                got.generation = m_tdata[43:12];
                sb.check_reply(got);
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stall before each transfer
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [31:0] idx,
                                input logic [31:0] gen);
        int gap;
        if ($urandom_range(0, 63) == 0)
            quiet = !quiet;
        gap = idle_draw();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {{S_PAD_W{1'b0}}, gen, idx, op};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // weights in percent; what is left over goes to the unused op code
    task automatic random_request(input int create_wt, input int free_wt, input int check_wt);
        int          pick;
        int          hw;
        int          r;
        logic [1:0]  op;
        logic [31:0] idx;
        logic [31:0] gen;
        hw = sb.high_water;
        idx = $urandom();
        gen = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < create_wt) begin
            op = OP_CREATE;
        end else if (pick < create_wt + free_wt) begin
            op = OP_FREE;
            r = $urandom_range(0, 7);
            if (hw > 0 && r < 7)
                idx = $urandom_range(0, hw - 1);
            else if (r == 7 && $urandom_range(0, 1))
                idx = hw + $urandom_range(0, 2);
        end else if (pick < create_wt + free_wt + check_wt) begin
            op = OP_VALIDATE;
            r = $urandom_range(0, 9);
            if (hw > 0 && r < 8) begin
                idx = $urandom_range(0, hw - 1);
                if (r < 6)
                    gen = sb.gen_table[int'(idx)];
                else if (r == 6)
                    gen = sb.gen_table[int'(idx)] - 1'b1;
            end else if (r == 8) begin
                idx = hw;
            end
        end else begin
            op = OP_UNUSED;
        end
        send_request(op, idx, gen);
    endtask

    initial begin
        sb = new();
        quiet = 1'b0;
        cycles = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty allocator: nothing handed out yet
        send_request(OP_VALIDATE, 32'd0, 32'd0);
        send_request(OP_FREE, 32'd0, 32'd0);
        send_request(OP_CREATE, 32'd0, 32'd0);
        send_request(OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_VALIDATE, 32'd0, 32'd0);
        send_request(OP_VALIDATE, 32'd0, 32'hFFFF_FFFF);
        send_request(OP_VALIDATE, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_VALIDATE, 32'h8000_0000, 32'd0);
        send_request(OP_FREE, 32'd1, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'hFFFF_FFFF, 32'd0);
        // low bits alias slot 0 but the index is out of range
        send_request(OP_FREE, 32'h0000_0400, 32'd0);
        send_request(OP_FREE, 32'd1, 32'd0);
        send_request(OP_VALIDATE, 32'd1, 32'd1);
        send_request(OP_VALIDATE, 32'd1, 32'd2);
        // slot 1 sits on the stack twice
        send_request(OP_CREATE, 32'd0, 32'd0);
        send_request(OP_CREATE, 32'd0, 32'd0);
        send_request(OP_CREATE, 32'd0, 32'd0);
        send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_UNUSED, 32'd0, 32'd0);
        send_request(OP_FREE, 32'd0, 32'hFFFF_FFFF);
        send_request(OP_VALIDATE, 32'd0, 32'd1);
        send_request(OP_VALIDATE, 32'd2, 32'd0);

        repeat (200) random_request(35, 30, 30);
        // run out of slots, then keep asking
        while (sb.create_refused < 3)
            random_request(92, 0, 6);
        // fill the free stack until pushes are refused
        while (sb.push_refused < 3)
            random_request(0, 95, 4);
        repeat (150) random_request(35, 30, 30);

        s_tvalid = 1'b0;
        while (sb.pending_replies.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        sb.final_check();
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
